>>> src/blrp_pkg.sv
// ---------------------------------------------------------------------------
// blrp_pkg
// Types and constants shared by the lease pool controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package blrp_pkg;

  localparam int unsigned NumSlotsDef = 16;
  localparam logic [63:0] LeaseTtlRst = 64'd100000000;

  localparam logic [2:0] ModeAcquire = 3'd0;
  localparam logic [2:0] ModePublish = 3'd1;
  localparam logic [2:0] ModeRetain  = 3'd2;
  localparam logic [2:0] ModeRelease = 3'd3;
  localparam logic [2:0] ModeReclaim = 3'd4;

  localparam logic [1:0] StFree      = 2'd0;
  localparam logic [1:0] StWriting   = 2'd1;
  localparam logic [1:0] StPublished = 2'd2;
  localparam logic [1:0] StReclaimed = 2'd3;

  localparam logic [1:0] RcOk    = 2'd0;
  localparam logic [1:0] RcFull  = 2'd1;
  localparam logic [1:0] RcRange = 2'd2;
  localparam logic [1:0] RcBad   = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  slot_index;
    logic [7:0]  ref_init;
    logic [63:0] frame_tag_in;
    logic [63:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  granted_slot;
    logic [7:0]  reclaimed_count;
    logic [7:0]  free_slots_out;
    logic [63:0] slot_frame_tag;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch request, clear scan pointer
    logic scan;     // examine slot at pointer, advance
    logic single;   // do publish/retain/release on addressed slot
    logic finish;   // build response
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic scan_done; // acquire found a slot
    logic is_scan;   // acquire or reclaim
  } dp_sts_t;

endpackage

`default_nettype wire

>>> src/buffer_lease_refcount_pool_core.sv
// ---------------------------------------------------------------------------
// buffer_lease_refcount_pool_core
// Reference-counted frame buffer pool with lease expiry.
// ---------------------------------------------------------------------------
// Flow: publish/retain/release update the addressed slot; acquire and reclaim
//   scan up to NumSlots slots, one slot examined per cycle by the scan.
// Throughput: one transaction at a time; start is taken when busy is low.
// Results show for one cycle on done_o; the receiver cannot stall.
// Reset: all slots free, counts/tags/expiry zero, lease_ttl 100000000.
`default_nettype none

module buffer_lease_refcount_pool_core #(
  parameter int unsigned NumSlots = blrp_pkg::NumSlotsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire blrp_pkg::req_t  req_i,
  output logic                 done_o,
  output blrp_pkg::rsp_t       rsp_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [63:0]     cfg_data_i
);
  import blrp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  blrp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  blrp_dp #(.NumSlots(NumSlots)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_valid_o(done_o),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

>>> src/blrp_ctrl.sv
// ---------------------------------------------------------------------------
// blrp_ctrl
// Sequencer: load, then either a slot scan or one update, then respond.
// ---------------------------------------------------------------------------
`default_nettype none

module blrp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  output blrp_pkg::dp_cmd_t      cmd_o,
  input  wire blrp_pkg::dp_sts_t sts_i
);
  import blrp_pkg::*;

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SDecide = 2'd1;
  localparam logic [1:0] SScan   = 2'd2;
  localparam logic [1:0] SFinish = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = SDecide;
        end
      end
      SDecide: begin
        if (sts_i.is_scan) begin
          state_d = SScan;
        end else begin
          cmd_o.single = 1'b1;
          state_d      = SFinish;
        end
      end
      SScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last || sts_i.scan_done) state_d = SFinish;
      end
      SFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else         state_q <= state_d;
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == SIdle) else $error("load outside idle");
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == SIdle) else $error("finish not followed by idle");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("multiple commands");

endmodule

`default_nettype wire

>>> src/blrp_dp.sv
// ---------------------------------------------------------------------------
// blrp_dp
// Slot tables, lease TTL register, scan pointer and response register.
// ---------------------------------------------------------------------------
`default_nettype none

module blrp_dp #(
  parameter int unsigned NumSlots = blrp_pkg::NumSlotsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire blrp_pkg::req_t    req_i,
  input  wire logic              cfg_we_i,
  input  wire logic [63:0]       cfg_data_i,
  input  wire blrp_pkg::dp_cmd_t cmd_i,
  output blrp_pkg::dp_sts_t      sts_o,
  output logic                   rsp_valid_o,
  output blrp_pkg::rsp_t         rsp_o
);
  import blrp_pkg::*;

  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  logic [1:0]  lst_q [NumSlots];
  logic [7:0]  cnt_q [NumSlots];
  logic [63:0] exp_q [NumSlots];
  logic [63:0] tag_q [NumSlots];
  logic [7:0]  free_q;
  logic [63:0] ttl_q;
  req_t        req_q;
  logic [IdxW-1:0] ptr_q;
  logic [1:0]  st_q;
  logic [7:0]  gr_q;
  logic [7:0]  rcl_q;
  logic        found_q;
  logic        rsp_valid_q;
  rsp_t        rsp_q;

  logic in_range;
  logic [IdxW-1:0] aidx;
  logic [63:0] expiry_new;
  logic ptr_last;

  assign in_range   = ({24'd0, req_q.slot_index} < 32'(NumSlots));
  assign aidx       = req_q.slot_index[IdxW-1:0];
  assign expiry_new = req_q.now_time + ttl_q;
  assign ptr_last   = ({{(32-IdxW){1'b0}}, ptr_q} == 32'(NumSlots - 1));

  assign sts_o.is_scan   = (req_q.mode == ModeAcquire) || (req_q.mode == ModeReclaim);
  assign sts_o.scan_last = ptr_last;
  assign sts_o.scan_done = (req_q.mode == ModeAcquire) &&
                           ((lst_q[ptr_q] == StFree) || (lst_q[ptr_q] == StReclaimed));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q       <= LeaseTtlRst;
      free_q      <= 8'(NumSlots);
      ptr_q       <= '0;
      st_q        <= RcBad;
      gr_q        <= '0;
      rcl_q       <= '0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        lst_q[i] <= StFree;
        cnt_q[i] <= '0;
        exp_q[i] <= '0;
        tag_q[i] <= '0;
      end
    end else begin
      rsp_valid_q <= cmd_i.finish;
      if (cfg_we_i) ttl_q <= cfg_data_i;
      if (cmd_i.load) begin
        ptr_q   <= '0;
        rcl_q   <= '0;
        found_q <= 1'b0;
        gr_q    <= '0;
        st_q    <= (req_i.mode == ModeAcquire) ? RcFull :
                   (req_i.mode == ModeReclaim) ? RcOk : RcBad;
      end
      if (cmd_i.scan) begin
        if (!ptr_last) ptr_q <= ptr_q + 1'b1;
        if (req_q.mode == ModeAcquire) begin
          if (sts_o.scan_done) begin
            tag_q[ptr_q] <= req_q.frame_tag_in;
            cnt_q[ptr_q] <= '0;
            exp_q[ptr_q] <= expiry_new;
            lst_q[ptr_q] <= StWriting;
            free_q       <= free_q - 8'd1;
            st_q         <= RcOk;
            gr_q         <= 8'(ptr_q);
            found_q      <= 1'b1;
          end
        end else if (lst_q[ptr_q] == StPublished && cnt_q[ptr_q] != 8'd0 &&
                     exp_q[ptr_q] <= req_q.now_time) begin
          lst_q[ptr_q] <= StReclaimed;
          cnt_q[ptr_q] <= '0;
          rcl_q        <= rcl_q + 8'd1;
          free_q       <= free_q + 8'd1;
        end
      end
      if (cmd_i.single) begin
        // unknown mode: granted slot stays at the zero set on load
        if (req_q.mode != ModePublish && req_q.mode != ModeRetain &&
            req_q.mode != ModeRelease) begin
          st_q <= RcBad;
        end else begin
          gr_q <= req_q.slot_index;
          if (!in_range) begin
            st_q <= RcRange;
          end else if (req_q.mode == ModePublish) begin
            if (req_q.ref_init != 8'd0 && lst_q[aidx] == StWriting) begin
              cnt_q[aidx] <= req_q.ref_init;
              exp_q[aidx] <= expiry_new;
              lst_q[aidx] <= StPublished;
              st_q        <= RcOk;
            end
          end else if (lst_q[aidx] == StPublished && cnt_q[aidx] != 8'd0) begin
            if (req_q.mode == ModeRetain) begin
              if (cnt_q[aidx] != 8'hFF) begin
                cnt_q[aidx] <= cnt_q[aidx] + 8'd1;
                st_q        <= RcOk;
              end
            end else begin
              cnt_q[aidx] <= cnt_q[aidx] - 8'd1;
              st_q        <= RcOk;
              if (cnt_q[aidx] == 8'd1) begin
                lst_q[aidx] <= StFree;
                tag_q[aidx] <= '0;
                exp_q[aidx] <= '0;
                free_q      <= free_q + 8'd1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q.status          <= st_q;
      rsp_q.granted_slot    <= gr_q;
      rsp_q.reclaimed_count <= rcl_q;
      rsp_q.free_slots_out  <= free_q;
      if (req_q.mode == ModeAcquire)
        rsp_q.slot_frame_tag <= found_q ? req_q.frame_tag_in : 64'd0;
      else if ((req_q.mode == ModePublish || req_q.mode == ModeRetain ||
                req_q.mode == ModeRelease) && in_range)
        rsp_q.slot_frame_tag <= tag_q[aidx];
      else
        rsp_q.slot_frame_tag <= 64'd0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= 8'(NumSlots)) else $error("free count overflow");
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> st_q == RcOk) else $error("acquire found but not ok");
  a_rcl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcl_q <= 8'(NumSlots)) else $error("reclaim count overflow");

endmodule

`default_nettype wire

>>> dv/tb_buffer_lease_refcount_pool_core.sv
// ---------------------------------------------------------------------------
// tb_buffer_lease_refcount_pool_core
// Self-checking bench for the lease pool: a directed table of requests, then
// random lease lifecycles and noise, each response compared with a predicted
// copy of the pool. lease_ttl is rewritten between phases while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_buffer_lease_refcount_pool_core;
  import blrp_pkg::*;

  localparam int unsigned NSlots = NumSlotsDef;
  localparam int unsigned StallMax = 2000;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  idx;
    logic [7:0]  rinit;
    logic [63:0] tag;
    logic [63:0] now;
    bit          has_exp;
    logic [1:0]  status;
    logic [7:0]  granted;
    logic [7:0]  freecnt;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i = '0;

  // predicted pool
  logic [1:0]  pool_state [NSlots];
  logic [7:0]  pool_count [NSlots];
  logic [63:0] pool_expiry [NSlots];
  logic [63:0] pool_tag [NSlots];
  logic [7:0]  pool_free;
  logic [63:0] ttl;

  rsp_t  rsp_queue[$];
  int    n_errors = 0;
  int    idle_cycles = 0;
  bit    no_gaps = 1'b0;
  logic [63:0] time_base = 64'd1000;

  always #1 clk_i = ~clk_i;

  buffer_lease_refcount_pool_core DUT (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  function automatic rsp_t lease_pool_step(req_t r);
    rsp_t o;
    logic [7:0] nrec;
    o = '0;
    o.status = RcBad;
    nrec = '0;
    case (r.mode)
      ModeAcquire: begin
        o.status = RcFull;
        for (int i = 0; i < NSlots; i++) begin
          if (o.status == RcFull &&
              (pool_state[i] == StFree || pool_state[i] == StReclaimed)) begin
            pool_tag[i] = r.frame_tag_in;
            pool_count[i] = '0;
            pool_expiry[i] = r.now_time + ttl;
            pool_state[i] = StWriting;
            pool_free = pool_free - 8'd1;
            o.status = RcOk;
            o.granted_slot = 8'(i);
            o.slot_frame_tag = r.frame_tag_in;
          end
        end
      end
      ModePublish, ModeRetain, ModeRelease: begin
        o.granted_slot = r.slot_index;
        if (r.slot_index >= NSlots) begin
          o.status = RcRange;
        end else begin
          if (r.mode == ModePublish) begin
            if (r.ref_init != 0 && pool_state[r.slot_index] == StWriting) begin
              pool_count[r.slot_index] = r.ref_init;
              pool_expiry[r.slot_index] = r.now_time + ttl;
              pool_state[r.slot_index] = StPublished;
              o.status = RcOk;
            end
          end else if (pool_state[r.slot_index] == StPublished &&
                       pool_count[r.slot_index] != 0) begin
            if (r.mode == ModeRetain) begin
              if (pool_count[r.slot_index] != 8'hff) begin
                pool_count[r.slot_index]++;
                o.status = RcOk;
              end
            end else begin
              pool_count[r.slot_index]--;
              o.status = RcOk;
              if (pool_count[r.slot_index] == 0) begin
                pool_state[r.slot_index] = StFree;
                pool_tag[r.slot_index] = '0;
                pool_expiry[r.slot_index] = '0;
                pool_free = pool_free + 8'd1;
              end
            end
          end
          o.slot_frame_tag = pool_tag[r.slot_index];
        end
      end
      ModeReclaim: begin
        for (int i = 0; i < NSlots; i++) begin
          if (pool_state[i] == StPublished && pool_count[i] != 0 &&
              pool_expiry[i] <= r.now_time) begin
            pool_state[i] = StReclaimed;
            pool_count[i] = '0;
            nrec++;
          end
        end
        pool_free = pool_free + nrec;
        o.reclaimed_count = nrec;
        o.status = RcOk;
      end
      default: ;
    endcase
    o.free_slots_out = pool_free;
    return o;
  endfunction

  task automatic compare_rsp(rsp_t e, rsp_t a);
    if (a.status !== e.status) begin
      $error("status exp %0d got %0d", e.status, a.status); n_errors++;
    end
    if (a.granted_slot !== e.granted_slot) begin
      $error("granted_slot exp %0d got %0d", e.granted_slot, a.granted_slot);
      n_errors++;
    end
    if (a.reclaimed_count !== e.reclaimed_count) begin
      $error("reclaimed_count exp %0d got %0d", e.reclaimed_count,
             a.reclaimed_count);
      n_errors++;
    end
    if (a.free_slots_out !== e.free_slots_out) begin
      $error("free_slots_out exp %0d got %0d", e.free_slots_out,
             a.free_slots_out);
      n_errors++;
    end
    if (a.slot_frame_tag !== e.slot_frame_tag) begin
      $error("slot_frame_tag exp %h got %h", e.slot_frame_tag, a.slot_frame_tag);
      n_errors++;
    end
  endtask

  // response checker
  always @(posedge clk_i) begin
    if (start && !busy) idle_cycles <= 0;
    else if (cfg_valid_i && cfg_ready_o) idle_cycles <= 0;
    else if (done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (done_o) begin
      if (rsp_queue.size() == 0) begin
        $error("response with none pending");
        n_errors++;
      end else begin
        rsp_t e;
        e = rsp_queue.pop_front();
        compare_rsp(e, rsp_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallMax) begin
      $display("tb_buffer_lease_refcount_pool_core: done, errors");
      $finish;
    end
  end

  task automatic random_gap();
    if (!no_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(negedge clk_i);
  endtask

  // drive one request with its predicted response; returns after the
  // transaction is taken, while the block is still busy with it
  task automatic send_exp(req_t r, rsp_t p);
    random_gap();
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    rsp_queue.push_back(p);
    @(negedge clk_i);
    start <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_req(req_t r);
    rsp_t p;
    p = lease_pool_step(r);
    send_exp(r, p);
  endtask

  task automatic drain();
    while (rsp_queue.size() != 0) @(negedge clk_i);
    repeat (NSlots + 8) @(negedge clk_i);
  endtask

  task automatic write_ttl(logic [63:0] v);
    drain();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    ttl = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t make_req(logic [2:0] m, logic [7:0] i, logic [7:0] ri,
                                    logic [63:0] tg, logic [63:0] nw);
    req_t r;
    r.mode = m; r.slot_index = i; r.ref_init = ri; r.frame_tag_in = tg; r.now_time = nw;
    return r;
  endfunction

  // mostly lease lifecycles: acquire, publish, a few retains/releases, reclaim
  task automatic random_phase(int n_items);
    int sent;
    req_t r;
    logic [7:0] idx;
    sent = 0;
    while (sent < n_items) begin
      time_base = time_base + $urandom_range(0, 4000);
      case ($urandom_range(0, 9))
        0: r = make_req(3'($urandom_range(0, 7)), 8'($urandom()), 8'($urandom()),
                        rand64(), rand64());
        1: r = make_req(ModeReclaim, 8'($urandom()), 8'($urandom()), rand64(),
                        ($urandom_range(0, 9) == 0) ? rand64() : time_base);
        2, 3: r = make_req(ModeAcquire, 8'($urandom()), 8'($urandom()), rand64(),
                           time_base);
        4, 5: begin
          idx = ($urandom_range(0, 15) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 15));
          r = make_req(ModePublish, idx,
                       ($urandom_range(0, 9) == 0) ? 8'd0 :
                       ($urandom_range(0, 5) == 0) ? 8'($urandom_range(250, 255)) :
                       8'($urandom_range(1, 4)), rand64(), time_base);
        end
        6: r = make_req(ModeRetain, 8'($urandom_range(0, 15)), 8'($urandom()), rand64(),
                        time_base);
        default: r = make_req(ModeRelease, 8'($urandom_range(0, 15)), 8'($urandom()),
                              rand64(), time_base);
      endcase
      send_req(r);
      sent++;
    end
  endtask

  dir_row_t dir_rows[$];

  task automatic add_row(logic [2:0] m, logic [7:0] i, logic [7:0] ri, logic [63:0] tg,
                         logic [63:0] nw, bit he, logic [1:0] st, logic [7:0] gs,
                         logic [7:0] fc);
    dir_rows.push_back('{m, i, ri, tg, nw, he, st, gs, fc});
  endtask

  initial begin
    rsp_t e;
    for (int i = 0; i < NSlots; i++) begin
      pool_state[i] = StFree; pool_count[i] = '0; pool_expiry[i] = '0; pool_tag[i] = '0;
    end
    pool_free = 8'(NSlots);
    ttl = LeaseTtlRst;

    add_row(ModeRetain, 8'd0, 8'd0, '0, '0, 1, RcBad, 8'd0, 8'(NSlots));
    add_row(ModePublish, 8'hff, 8'd1, '0, '0, 1, RcRange, 8'hff, 8'(NSlots));
    add_row(ModeRelease, 8'(NSlots), 8'd1, '0, '0, 1, RcRange, 8'(NSlots), 8'(NSlots));
    add_row(3'd5, 8'd3, 8'd3, '1, '1, 1, RcBad, 8'd0, 8'(NSlots));
    add_row(3'd7, 8'hff, 8'hff, '1, '1, 1, RcBad, 8'd0, 8'(NSlots));
    add_row(ModeAcquire, 8'd0, 8'd0, '1, 64'd10, 1, RcOk, 8'd0, 8'(NSlots - 1));
    add_row(ModePublish, 8'd0, 8'd0, '0, 64'd10, 1, RcBad, 8'd0, 8'(NSlots - 1));
    add_row(ModePublish, 8'd0, 8'd255, '0, 64'd10, 1, RcOk, 8'd0, 8'(NSlots - 1));
    add_row(ModeRetain, 8'd0, 8'd0, '0, 64'd10, 1, RcBad, 8'd0, 8'(NSlots - 1));
    add_row(ModePublish, 8'd0, 8'd1, '0, 64'd10, 1, RcBad, 8'd0, 8'(NSlots - 1));
    add_row(ModeRelease, 8'd0, 8'd0, '0, 64'd10, 0, RcOk, 8'd0, 8'd0);
    add_row(ModeAcquire, 8'd0, 8'd0, 64'h0123456789abcdef, '1, 0, RcOk, 8'd0, 8'd0);
    add_row(ModePublish, 8'd1, 8'd1, '0, '1, 0, RcOk, 8'd0, 8'd0);
    add_row(ModeReclaim, 8'd0, 8'd0, '0, '0, 0, RcOk, 8'd0, 8'd0);
    add_row(ModeReclaim, 8'd0, 8'd0, '0, '1, 0, RcOk, 8'd0, 8'd0);
    add_row(ModeRelease, 8'd0, 8'd0, '0, '1, 0, RcOk, 8'd0, 8'd0);
    for (int i = 0; i < NSlots + 1; i++)
      add_row(ModeAcquire, 8'd0, 8'd0, 64'(i), 64'd5, 0, RcOk, 8'd0, 8'd0);
    add_row(ModeRelease, 8'd1, 8'd1, '0, '0, 0, RcOk, 8'd0, 8'd0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) begin
      req_t r;
      rsp_t p;
      r = make_req(dir_rows[k].mode, dir_rows[k].idx, dir_rows[k].rinit,
                   dir_rows[k].tag, dir_rows[k].now);
      if (dir_rows[k].has_exp) begin
        e = '0;
        e.status = dir_rows[k].status;
        e.granted_slot = dir_rows[k].granted;
        e.free_slots_out = dir_rows[k].freecnt;
        // none of these rows frees a slot, so the stored tag is the one reported
        if (dir_rows[k].status == RcOk && dir_rows[k].mode == ModeAcquire)
          e.slot_frame_tag = dir_rows[k].tag;
        else if (dir_rows[k].status != RcRange && dir_rows[k].mode inside {[1:3]})
          e.slot_frame_tag = pool_tag[dir_rows[k].idx];
        p = lease_pool_step(r);
        compare_rsp(e, p);
        send_exp(r, p);
      end else begin
        send_req(r);
      end
    end

    // sweep ttl settings including the extremes, with random traffic after each
    write_ttl(64'd0);
    random_phase(40);
    write_ttl('1);
    random_phase(60);
    write_ttl(64'd1);
    random_phase(60);
    // wait for every pending response before continuing
    while (rsp_queue.size() != 0) @(negedge clk_i);
    write_ttl(64'd2000);
    random_phase(150);
    write_ttl(rand64());
    random_phase(60);
    write_ttl(64'd5000);
    random_phase(100);
    no_gaps = 1'b1;
    random_phase(80);

    drain();
    if (n_errors == 0) begin
      $display("tb_buffer_lease_refcount_pool_core: done, clean");
    end else begin
      $display("tb_buffer_lease_refcount_pool_core: done, errors");
    end
    $finish;
  end

endmodule
